// ===== design/scp_pkg.sv =====
// Shared types, constants and helpers for the sine/cosine polynomial pipeline.
package scp_pkg;

    typedef logic signed [32:0] t_fix;
    typedef logic signed [47:0] t_red;

    localparam logic [31:0] INV_TWO_PI_Q32 = 32'h28BE60DC;
    localparam logic [46:0] TWO_PI_Q44     = 47'h6487ED5110B4;
    localparam t_red        PI_Q44         = 48'sh3243F6A8885A;
    localparam t_red        HALF_PI_Q44    = 48'sh1921FB54442D;

    localparam t_fix ONE_Q30 = 33'sd1073741824;
    localparam t_fix ZERO_Q30 = 33'sd0;

    localparam int HORNER_STEPS = 5;

    localparam t_fix SIN_K5 = -33'sd26;
    localparam t_fix COS_K5 = -33'sd280;

    localparam t_fix SIN_K [HORNER_STEPS] = '{
        33'sd2956, -33'sd213040, 33'sd8947846, -33'sd178956974, 33'sd1073741824
    };
    localparam t_fix COS_K [HORNER_STEPS] = '{
        33'sd26586, -33'sd1491253, 33'sd44739212, -33'sd536870912, 33'sd1073741824
    };

    function automatic logic [31:0] fix_mag(input t_fix v);
        t_fix n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

endpackage

// ===== design/scp_mac.sv =====
// Two-stage Q30 multiply with round-half-away rounding and a constant add.
module scp_mac import scp_pkg::*; (
    input  logic i_clk,
    input  t_fix i_a,
    input  t_fix i_b,
    input  t_fix i_k,
    output t_fix o_p
);

    localparam logic [63:0] ROUND_Q30 = 64'h0000_0000_2000_0000;

    logic        r_neg;
    logic [63:0] r_prod;
    t_fix        r_k;

    logic [31:0]        w_ma;
    logic [31:0]        w_mb;
    logic [63:0]        n_prod;
    logic [63:0]        w_rnd;
    logic signed [34:0] w_m;
    logic signed [34:0] w_sum;
    t_fix               n_p;

    always_comb begin
        w_ma   = fix_mag(i_a);
        w_mb   = fix_mag(i_b);
        n_prod = 64'(w_ma) * 64'(w_mb);
        w_rnd  = r_prod + ROUND_Q30;
        w_m    = $signed({1'b0, w_rnd[63:30]});
        w_sum  = (r_neg ? -w_m : w_m) + 35'(r_k);
        n_p    = w_sum[32:0];
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= i_a[32] ^ i_b[32];
        r_prod <= n_prod;
        r_k    <= i_k;
        o_p    <= n_p;
    end

endmodule

// ===== design/sine_cosine_polynomial.sv =====
// Pipelined sine and cosine of a Q16.16 angle by range reduction and polynomials.
//
// An item is an angle in radians, signed Q16.16, on i_angle. It is accepted
// at a rising edge where start is high and busy is low; busy is always low,
// so one item can be accepted every cycle.
// Each item yields one result: o_sine and o_cosine, signed Q2.30, shown for
// exactly one cycle with o_valid high. The result of an item accepted at one
// edge reaches the ports through the register stages listed below; the
// throughput is one item per cycle.
// The latency is set by the chain of multiplies, all 32x32 but the turn
// product: turn count, turn product, the square of the reduced angle, five
// Horner steps and the final sine product each take their own register
// stages, plus fold, rounding and saturation stages.
// Results come out in the order items went in. The receiver cannot stall.
// A synchronous reset on i_rst_n clears all valid bits, dropping every item
// in flight; no result appears until new items are accepted.
module sine_cosine_polynomial import scp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    output logic signed [31:0] o_sine,
    output logic signed [31:0] o_cosine
);

    localparam int VLD_LEN = 20;
    localparam int Y_LEN   = 12;
    localparam int CN_LEN  = 15;
    localparam int Y2_LEN  = 2 * HORNER_STEPS - 2;

    logic w_accept;

    logic [VLD_LEN-1:0] r_vld;

    logic signed [31:0] r1_x;
    logic [63:0]        r1_prod;
    logic signed [31:0] r2_x;
    logic [13:0]        r2_turns;
    logic signed [31:0] r3_x;
    logic [60:0]        r3_tp;
    t_red               r4_r;
    t_red               r5_r;
    logic               r5_cneg;
    t_fix               r6_y;

    t_fix r_y_d  [Y_LEN];
    logic r_cn_d [CN_LEN];
    t_fix r_y2_d [Y2_LEN];
    t_fix r_c_d  [2];

    logic [31:0]        w_mag;
    logic [63:0]        n_prod;
    logic [63:0]        w_trnd;
    logic signed [63:0] w_xs;
    logic signed [63:0] w_tps;
    logic signed [63:0] n_r;
    t_red               n_fold;
    logic               n_cneg;
    logic [47:0]        w_rmag;
    logic [47:0]        w_rrnd;
    logic signed [34:0] w_ym;
    t_fix               n_y;

    t_fix w_y2;
    t_fix w_p   [HORNER_STEPS+1];
    t_fix w_c   [HORNER_STEPS+1];
    t_fix w_y2t [HORNER_STEPS];
    t_fix w_s;
    t_fix w_cs;
    t_fix n_sine;
    t_fix n_cosine;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_comb begin
        w_mag  = i_angle[31] ? (~i_angle + 32'd1) : i_angle;
        n_prod = 64'(w_mag) * 64'(INV_TWO_PI_Q32);
        w_trnd = r1_prod + 64'h0000_8000_0000_0000;
        w_xs   = {{4{r3_x[31]}}, r3_x, 28'd0};
        w_tps  = {3'd0, r3_tp};
        n_r    = r3_x[31] ? (w_xs + w_tps) : (w_xs - w_tps);
        n_fold = r4_r;
        n_cneg = 1'b0;
        if (r4_r > HALF_PI_Q44) begin
            n_fold = PI_Q44 - r4_r;
            n_cneg = 1'b1;
        end else if (r4_r < -HALF_PI_Q44) begin
            n_fold = -PI_Q44 - r4_r;
            n_cneg = 1'b1;
        end
        w_rmag = r5_r[47] ? 48'(-r5_r) : r5_r;
        w_rrnd = w_rmag + 48'd8192;
        w_ym   = $signed({1'b0, w_rrnd[47:14]});
        n_y    = r5_r[47] ? 33'(-w_ym) : 33'(w_ym);
    end

    always_ff @(posedge i_clk) begin
        r1_x     <= i_angle;
        r1_prod  <= n_prod;
        r2_x     <= r1_x;
        r2_turns <= w_trnd[61:48];
        r3_x     <= r2_x;
        r3_tp    <= 61'(r2_turns) * 61'(TWO_PI_Q44);
        r4_r     <= n_r[47:0];
        r5_r     <= n_fold;
        r5_cneg  <= n_cneg;
        r6_y     <= n_y;
        r_y_d[0]  <= r6_y;
        r_cn_d[0] <= r5_cneg;
        r_y2_d[0] <= w_y2;
        r_c_d[0]  <= w_c[HORNER_STEPS];
        r_c_d[1]  <= r_c_d[0];
        for (int i = 1; i < Y_LEN; i++) begin
            r_y_d[i] <= r_y_d[i-1];
        end
        for (int i = 1; i < CN_LEN; i++) begin
            r_cn_d[i] <= r_cn_d[i-1];
        end
        for (int i = 1; i < Y2_LEN; i++) begin
            r_y2_d[i] <= r_y2_d[i-1];
        end
    end

    scp_mac u_square (
        .i_clk (i_clk),
        .i_a   (r6_y),
        .i_b   (r6_y),
        .i_k   (ZERO_Q30),
        .o_p   (w_y2)
    );

    assign w_p[0] = SIN_K5;
    assign w_c[0] = COS_K5;

    for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_step
        if (g == 0) begin : g_first
            assign w_y2t[g] = w_y2;
        end else begin : g_next
            assign w_y2t[g] = r_y2_d[2*g-1];
        end

        scp_mac u_sin (
            .i_clk (i_clk),
            .i_a   (w_p[g]),
            .i_b   (w_y2t[g]),
            .i_k   (SIN_K[g]),
            .o_p   (w_p[g+1])
        );

        scp_mac u_cos (
            .i_clk (i_clk),
            .i_a   (w_c[g]),
            .i_b   (w_y2t[g]),
            .i_k   (COS_K[g]),
            .o_p   (w_c[g+1])
        );
    end

    scp_mac u_sine_out (
        .i_clk (i_clk),
        .i_a   (w_p[HORNER_STEPS]),
        .i_b   (r_y_d[Y_LEN-1]),
        .i_k   (ZERO_Q30),
        .o_p   (w_s)
    );

    always_comb begin
        w_cs = r_cn_d[CN_LEN-1] ? -r_c_d[1] : r_c_d[1];
        if (w_s > ONE_Q30) begin
            n_sine = ONE_Q30;
        end else if (w_s < -ONE_Q30) begin
            n_sine = -ONE_Q30;
        end else begin
            n_sine = w_s;
        end
        if (w_cs > ONE_Q30) begin
            n_cosine = ONE_Q30;
        end else if (w_cs < -ONE_Q30) begin
            n_cosine = -ONE_Q30;
        end else begin
            n_cosine = w_cs;
        end
    end

    always_ff @(posedge i_clk) begin
        o_sine   <= n_sine[31:0];
        o_cosine <= n_cosine[31:0];
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[VLD_LEN-2:0], w_accept};
            o_valid <= r_vld[VLD_LEN-1];
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##21 o_valid)
        else $error("Accepted item did not produce a result after the pipeline latency.");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_sine) <= 32'sd1073741824 && $signed(o_sine) >= -32'sd1073741824))
        else $error("Sine result outside the saturation range.");

    a_cosine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_cosine) <= 32'sd1073741824
                     && $signed(o_cosine) >= -32'sd1073741824))
        else $error("Cosine result outside the saturation range.");

    a_valid_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && r_vld == '0)
        else $error("Valid bits not cleared by reset.");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the pipelined fixed-point sine/cosine unit.
module tb;

    typedef struct packed {
        logic signed [31:0] sine;
        logic signed [31:0] cosine;
    } sincos_t;

    localparam longint unsigned INV_TURN_Q32 = 64'h28BE60DC;
    localparam longint FULL_TURN_Q44 = 64'sh6487ED5110B4;
    localparam longint HALF_TURN_Q44 = 64'sh3243F6A8885A;
    localparam longint QUARTER_TURN_Q44 = 64'sh1921FB54442D;
    localparam longint UNIT_Q30 = 64'sd1073741824;
    localparam int MAX_GAP = 17;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [31:0] i_angle = '0;
    logic busy;
    logic o_valid;
    logic signed [31:0] o_sine;
    logic signed [31:0] o_cosine;

    sincos_t pending_trig [$];
    int mismatch_count = 0;

    sine_cosine_polynomial u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_angle  (i_angle),
        .o_valid  (o_valid),
        .o_sine   (o_sine),
        .o_cosine (o_cosine)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint unsigned mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        longint unsigned m;
        m = (mag_of(a) * mag_of(b) + 64'd536870912) >> 30;
        return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > UNIT_Q30) return UNIT_Q30;
        if (v < -UNIT_Q30) return -UNIT_Q30;
        return v;
    endfunction

    function automatic longint horner(input longint k5, input longint k4, input longint k3,
                                      input longint k2, input longint k1, input longint z);
        longint acc;
        acc = k5;
        acc = q30_mul(acc, z) + k4;
        acc = q30_mul(acc, z) + k3;
        acc = q30_mul(acc, z) + k2;
        acc = q30_mul(acc, z) + k1;
        acc = q30_mul(acc, z) + UNIT_Q30;
        return acc;
    endfunction

    function automatic sincos_t calc_sin_cos(input logic signed [31:0] angle);
        longint x;
        longint q;
        longint r;
        longint y;
        longint y2;
        longint s;
        longint c;
        longint unsigned turns;
        longint unsigned y_mag;
        bit folded;
        sincos_t res;
        x = angle;
        turns = (mag_of(x) * INV_TURN_Q32 + 64'd140737488355328) >> 48;
        q = (x < 0) ? -$signed(turns) : $signed(turns);
        r = x * 64'sd268435456 - q * FULL_TURN_Q44;
        folded = 1'b0;
        if (r > QUARTER_TURN_Q44) begin
            r = HALF_TURN_Q44 - r;
            folded = 1'b1;
        end else if (r < -QUARTER_TURN_Q44) begin
            r = -HALF_TURN_Q44 - r;
            folded = 1'b1;
        end
        y_mag = (mag_of(r) + 64'd8192) >> 14;
        y = (r < 0) ? -$signed(y_mag) : $signed(y_mag);
        y2 = q30_mul(y, y);
        s = horner(-26, 2956, -213040, 8947846, -178956974, y2);
        s = clamp_unit(q30_mul(s, y));
        c = horner(-280, 26586, -1491253, 44739212, -536870912, y2);
        if (folded) begin
            c = -c;
        end
        c = clamp_unit(c);
        res.sine = s[31:0];
        res.cosine = c[31:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : result_check
        sincos_t want;
        if (i_rst_n && o_valid) begin
            if (pending_trig.size() == 0) begin
                $error("unexpected result: sine %0d, cosine %0d", o_sine, o_cosine);
                mismatch_count++;
            end else begin
                want = pending_trig.pop_front();
                if (o_sine !== want.sine) begin
                    $error("sine: expected %0d, got %0d", want.sine, o_sine);
                    mismatch_count++;
                end
                if (o_cosine !== want.cosine) begin
                    $error("cosine: expected %0d, got %0d", want.cosine, o_cosine);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_angle(input logic signed [31:0] angle, input int max_gap);
        int gap;
        gap = $urandom_range(max_gap, 0);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_angle <= angle;
        do @(posedge i_clk); while (busy);
        pending_trig.push_back(calc_sin_cos(angle));
    endtask

    // Zero, unit steps, range limits, both sides of 1/4, 1/2, 3/4 turns, near full turns.
    task automatic test_corner_angles();
        int corners [24];
        corners = '{0, 1, -1, 65536, -65536, 32'sh7FFFFFFF, 32'sh80000000,
                    32'sh7FFF0000, 32'sh80010000, 102943, 102944, -102943, -102944,
                    205887, 205888, -205887, -205888, 308831, 308832, 411775,
                    411776, -411776, 617662, -617663};
        foreach (corners[i]) begin
            send_angle(corners[i], MAX_GAP);
        end
    endtask

    task automatic test_full_range();
        int burst_gap;
        for (int i = 0; i < 500; i++) begin
            if (i % 25 == 0) begin
                burst_gap = ($urandom_range(3, 0) == 0) ? 0 : MAX_GAP;
            end
            send_angle($urandom, burst_gap);
        end
    endtask

    task automatic test_few_turns();
        int angle;
        for (int i = 0; i < 400; i++) begin
            angle = int'($urandom_range(1647100, 0)) - 823550;
            send_angle(angle, MAX_GAP);
        end
    endtask

    // Angles a few LSBs from multiples of a quarter turn exercise folding and turn rounding.
    task automatic test_quadrant_edges();
        int k;
        int angle;
        for (int i = 0; i < 250; i++) begin
            k = int'($urandom_range(40000, 0)) - 20000;
            angle = $rtoi(k * 102943.70864) + int'($urandom_range(6, 0)) - 3;
            send_angle(angle, MAX_GAP);
        end
    endtask

    task automatic test_back_to_back();
        for (int i = 0; i < 150; i++) begin
            send_angle($urandom, 0);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_angles();
        test_full_range();
        test_few_turns();
        test_quadrant_edges();
        test_back_to_back();
        start <= 1'b0;
        while (pending_trig.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/scp_pkg.sv
design/scp_mac.sv
design/sine_cosine_polynomial.sv
sim/tb.sv
